FILE: design/longest_remaining_time_first_scheduler_defines.svh
// ----------------------------------------------------------------------------
// LRTF scheduler assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LONGEST_REMAINING_TIME_FIRST_SCHEDULER_DEFINES_SVH
`define LONGEST_REMAINING_TIME_FIRST_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRTF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lrtf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LRTF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lrtf assertion failed");

`endif

FILE: design/lrtf_pkg.sv
// ----------------------------------------------------------------------------
// LRTF scheduler package
// Sizes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrtf_pkg;

   localparam int MAX_JOBS  = 16;
   localparam int JOB_IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int JOB_CNT_W = $clog2(MAX_JOBS + 1);

   localparam int FIELD_W   = 16;
   localparam int TICK_W    = 21;
   localparam int SUM_W     = 25;
   localparam int COUNT_W   = 5;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_RUN  = 6'b000100,
      ST_TAT  = 6'b001000,
      ST_WAIT = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // store the request job
      logic scan;       // examine one table entry
      logic run_tick;   // run the chosen job for one tick
      logic jump;       // advance time to the next pending arrival
      logic calc_tat;   // compute turnaround
      logic calc_wt;    // compute waiting time
      logic emit;       // publish a result and update the totals
      logic abort;      // end the run without further results
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_end;   // current scan entry is the last loaded one
      logic found;      // an eligible job was chosen by the last scan
      logic last_tick;  // the chosen job has exactly one tick left
      logic jump_ok;    // a pending arrival lies in the future
      logic run_done;   // the job being reported is the last one of the set
   } status_type;

endpackage

FILE: design/lrtf_ctrl.sv
// ----------------------------------------------------------------------------
// LRTF scheduler controller
// Sequences loading, table scans, tick execution and result reporting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrtf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_last_job,
   input  lrtf_pkg::status_type status,
   output lrtf_pkg::cmd_type    cmd,
   output logic                busy
);
   import lrtf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_last_job) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_end) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.found) begin
               cmd.run_tick = 1'b1;
               state_in     = status.last_tick ? ST_TAT : ST_SCAN;
            end else if (status.jump_ok) begin
               cmd.jump = 1'b1;
               state_in = ST_SCAN;
            end else begin
               cmd.abort = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_TAT: begin
            cmd.calc_tat = 1'b1;
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            cmd.calc_wt = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = status.run_done ? ST_IDLE : ST_SCAN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: design/lrtf_datapath.sv
// ----------------------------------------------------------------------------
// LRTF scheduler datapath
// Job table, scan comparators, tick counter, result arithmetic and outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrtf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lrtf_pkg::cmd_type                    cmd,
   output lrtf_pkg::status_type                 status,
   input  logic [lrtf_pkg::FIELD_W-1:0]         req_job_id,
   input  logic [lrtf_pkg::FIELD_W-1:0]         req_arrival_tick,
   input  logic [lrtf_pkg::FIELD_W-1:0]         req_burst_ticks,
   output logic                                rsp_valid,
   output logic [lrtf_pkg::FIELD_W-1:0]         rsp_done_id,
   output logic [lrtf_pkg::TICK_W-1:0]          rsp_completion_tick,
   output logic [lrtf_pkg::TICK_W-1:0]          rsp_turnaround,
   output logic [lrtf_pkg::TICK_W-1:0]          rsp_waiting,
   output logic [lrtf_pkg::SUM_W-1:0]           rsp_total_turnaround,
   output logic [lrtf_pkg::SUM_W-1:0]           rsp_total_waiting,
   output logic [lrtf_pkg::COUNT_W-1:0]         rsp_job_count,
   output logic                                rsp_final_result
);
   import lrtf_pkg::*;

   // Job table.
   logic [FIELD_W-1:0] id_mem      [MAX_JOBS];
   logic [FIELD_W-1:0] arrival_mem [MAX_JOBS];
   logic [FIELD_W-1:0] burst_mem   [MAX_JOBS];
   logic [FIELD_W-1:0] remain_mem  [MAX_JOBS];

   // Table read port. It is addressed with the next scan index, so the entry
   // under the scan index is already registered when the scan looks at it.
   logic [FIELD_W-1:0]   rd_id_ff;
   logic [FIELD_W-1:0]   rd_arr_ff;
   logic [FIELD_W-1:0]   rd_burst_ff;
   logic [FIELD_W-1:0]   rd_rem_ff;

   // Run control state.
   logic [JOB_CNT_W-1:0] count_ff, count_in;
   logic [JOB_CNT_W-1:0] fin_ff, fin_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [SUM_W-1:0]     sum_tat_ff, sum_tat_in;
   logic [SUM_W-1:0]     sum_wt_ff, sum_wt_in;
   logic [JOB_IDX_W-1:0] scan_idx_ff, scan_idx_in;

   // Scan results.
   logic                 found_ff, found_in;
   logic                 any_ff, any_in;
   logic [JOB_IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [FIELD_W-1:0]   best_rem_ff, best_rem_in;
   logic [FIELD_W-1:0]   best_arr_ff, best_arr_in;
   logic [FIELD_W-1:0]   best_burst_ff, best_burst_in;
   logic [FIELD_W-1:0]   best_id_ff, best_id_in;
   logic [FIELD_W-1:0]   next_arr_ff, next_arr_in;

   // Finish arithmetic.
   logic [TICK_W-1:0]    tat_ff;
   logic [TICK_W-1:0]    wt_ff;

   logic                 rsp_valid_ff;

   logic [FIELD_W-1:0]   entry_rem;
   logic [FIELD_W-1:0]   entry_arr;
   logic                 entry_pend;
   logic                 entry_elig;
   logic                 scan_first;
   logic                 base_found;
   logic                 base_any;
   logic                 table_room;
   logic [FIELD_W-1:0]   load_burst;
   logic [SUM_W-1:0]     total_tat;
   logic [SUM_W-1:0]     total_wt;

   assign entry_rem  = rd_rem_ff;
   assign entry_arr  = rd_arr_ff;
   assign entry_pend = (entry_rem != '0);
   assign entry_elig = entry_pend && ({{(TICK_W-FIELD_W){1'b0}}, entry_arr} <= tick_ff);
   assign scan_first = (scan_idx_ff == '0);
   assign base_found = scan_first ? 1'b0 : found_ff;
   assign base_any   = scan_first ? 1'b0 : any_ff;
   assign table_room = (count_ff < JOB_CNT_W'(MAX_JOBS));
   assign load_burst = (req_burst_ticks == '0) ? FIELD_W'(1) : req_burst_ticks;
   assign total_tat  = sum_tat_ff + {{(SUM_W-TICK_W){1'b0}}, tat_ff};
   assign total_wt   = sum_wt_ff + {{(SUM_W-TICK_W){1'b0}}, wt_ff};

   always_comb begin
      status.scan_end  = ((JOB_CNT_W'(scan_idx_ff) + JOB_CNT_W'(1)) == count_ff);
      status.found     = found_ff;
      status.last_tick = (best_rem_ff == FIELD_W'(1));
      status.jump_ok   = any_ff && ({{(TICK_W-FIELD_W){1'b0}}, next_arr_ff} > tick_ff);
      status.run_done  = ((fin_ff + JOB_CNT_W'(1)) == count_ff);
   end

   // Scan update: keep the largest remaining time among eligible jobs (earliest
   // entry wins a tie) and the earliest arrival among unfinished jobs.
   always_comb begin
      found_in      = found_ff;
      any_in        = any_ff;
      best_idx_in   = best_idx_ff;
      best_rem_in   = best_rem_ff;
      best_arr_in   = best_arr_ff;
      best_burst_in = best_burst_ff;
      best_id_in    = best_id_ff;
      next_arr_in   = next_arr_ff;
      scan_idx_in   = scan_idx_ff;
      if (cmd.scan) begin
         found_in    = base_found;
         any_in      = base_any;
         scan_idx_in = status.scan_end ? '0 : scan_idx_ff + JOB_IDX_W'(1);
         if (entry_elig && (!base_found || (entry_rem > best_rem_ff))) begin
            found_in      = 1'b1;
            best_idx_in   = scan_idx_ff;
            best_rem_in   = entry_rem;
            best_arr_in   = entry_arr;
            best_burst_in = rd_burst_ff;
            best_id_in    = rd_id_ff;
         end
         if (entry_pend && (!base_any || (entry_arr < next_arr_ff))) begin
            any_in      = 1'b1;
            next_arr_in = entry_arr;
         end
      end
   end

   // Run counters and totals.
   always_comb begin
      count_in   = count_ff;
      fin_in     = fin_ff;
      tick_in    = tick_ff;
      sum_tat_in = sum_tat_ff;
      sum_wt_in  = sum_wt_ff;
      if (cmd.load && table_room) begin
         count_in = count_ff + JOB_CNT_W'(1);
      end
      if (cmd.run_tick) begin
         tick_in = tick_ff + TICK_W'(1);
      end
      if (cmd.jump) begin
         tick_in = {{(TICK_W-FIELD_W){1'b0}}, next_arr_ff};
      end
      if (cmd.emit) begin
         fin_in     = fin_ff + JOB_CNT_W'(1);
         sum_tat_in = total_tat;
         sum_wt_in  = total_wt;
      end
      if ((cmd.emit && status.run_done) || cmd.abort) begin
         count_in   = '0;
         fin_in     = '0;
         tick_in    = '0;
         sum_tat_in = '0;
         sum_wt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         fin_ff       <= '0;
         tick_ff      <= '0;
         sum_tat_ff   <= '0;
         sum_wt_ff    <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         fin_ff       <= fin_in;
         tick_ff      <= tick_in;
         sum_tat_ff   <= sum_tat_in;
         sum_wt_ff    <= sum_wt_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      found_ff      <= found_in;
      any_ff        <= any_in;
      best_idx_ff   <= best_idx_in;
      best_rem_ff   <= best_rem_in;
      best_arr_ff   <= best_arr_in;
      best_burst_ff <= best_burst_in;
      best_id_ff    <= best_id_in;
      next_arr_ff   <= next_arr_in;
      if (cmd.calc_tat) begin
         tat_ff <= tick_ff - {{(TICK_W-FIELD_W){1'b0}}, best_arr_ff};
      end
      if (cmd.calc_wt) begin
         wt_ff <= tat_ff - {{(TICK_W-FIELD_W){1'b0}}, best_burst_ff};
      end
   end

   // Job table writes: loading fills the next free entry, a run tick
   // decrements the chosen job's remaining time. The read port passes a write
   // to the entry it is reading straight through.
   always_ff @(posedge clock) begin
      if (cmd.load && table_room) begin
         id_mem[count_ff[JOB_IDX_W-1:0]]      <= req_job_id;
         arrival_mem[count_ff[JOB_IDX_W-1:0]] <= req_arrival_tick;
         burst_mem[count_ff[JOB_IDX_W-1:0]]   <= load_burst;
      end
      if (cmd.load && table_room) begin
         remain_mem[count_ff[JOB_IDX_W-1:0]] <= load_burst;
      end else if (cmd.run_tick) begin
         remain_mem[best_idx_ff] <= best_rem_ff - FIELD_W'(1);
      end
      if (cmd.load && table_room && (count_ff[JOB_IDX_W-1:0] == scan_idx_in)) begin
         rd_id_ff    <= req_job_id;
         rd_arr_ff   <= req_arrival_tick;
         rd_burst_ff <= load_burst;
         rd_rem_ff   <= load_burst;
      end else begin
         rd_id_ff    <= id_mem[scan_idx_in];
         rd_arr_ff   <= arrival_mem[scan_idx_in];
         rd_burst_ff <= burst_mem[scan_idx_in];
         if (cmd.run_tick && (best_idx_ff == scan_idx_in)) begin
            rd_rem_ff <= best_rem_ff - FIELD_W'(1);
         end else begin
            rd_rem_ff <= remain_mem[scan_idx_in];
         end
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_done_id          <= best_id_ff;
         rsp_completion_tick  <= tick_ff;
         rsp_turnaround       <= tat_ff;
         rsp_waiting          <= wt_ff;
         rsp_total_turnaround <= total_tat;
         rsp_total_waiting    <= total_wt;
         rsp_job_count        <= COUNT_W'(count_ff);
         rsp_final_result     <= status.run_done;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/longest_remaining_time_first_scheduler.sv
// ----------------------------------------------------------------------------
// Longest-remaining-time-first scheduler
// Jobs load one per cycle while busy is low; a transaction with last_job set
// ends loading, and busy stays high for the whole schedule of that set.
// Each simulated tick or idle jump is a scan of the job table, one entry per
// cycle, and a run step; a finishing job adds turnaround, waiting and report
// steps, the result strobing the cycle after report. No result can be stalled.
// Synchronous reset returns the block to idle with an empty job table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "longest_remaining_time_first_scheduler_defines.svh"

module longest_remaining_time_first_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lrtf_pkg::FIELD_W-1:0]         req_job_id,
   input  logic [lrtf_pkg::FIELD_W-1:0]         req_arrival_tick,
   input  logic [lrtf_pkg::FIELD_W-1:0]         req_burst_ticks,
   input  logic                                req_last_job,
   output logic                                rsp_valid,
   output logic [lrtf_pkg::FIELD_W-1:0]         rsp_done_id,
   output logic [lrtf_pkg::TICK_W-1:0]          rsp_completion_tick,
   output logic [lrtf_pkg::TICK_W-1:0]          rsp_turnaround,
   output logic [lrtf_pkg::TICK_W-1:0]          rsp_waiting,
   output logic [lrtf_pkg::SUM_W-1:0]           rsp_total_turnaround,
   output logic [lrtf_pkg::SUM_W-1:0]           rsp_total_waiting,
   output logic [lrtf_pkg::COUNT_W-1:0]         rsp_job_count,
   output logic                                rsp_final_result
);
   import lrtf_pkg::*;

   // The controller walks through the states below for a set of jobs:
   // idle (loading), scan of the job table, one tick of execution or an idle
   // jump to the next arrival, and for a finishing job the turnaround,
   // waiting and report steps. The datapath holds the table and all
   // arithmetic, and publishes each result transaction as a one-cycle strobe.
   cmd_type    cmd;
   status_type status;

   lrtf_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_last_job (req_last_job),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy)
   );

   lrtf_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_job_id           (req_job_id),
      .req_arrival_tick     (req_arrival_tick),
      .req_burst_ticks      (req_burst_ticks),
      .rsp_valid            (rsp_valid),
      .rsp_done_id          (rsp_done_id),
      .rsp_completion_tick  (rsp_completion_tick),
      .rsp_turnaround       (rsp_turnaround),
      .rsp_waiting          (rsp_waiting),
      .rsp_total_turnaround (rsp_total_turnaround),
      .rsp_total_waiting    (rsp_total_waiting),
      .rsp_job_count        (rsp_job_count),
      .rsp_final_result     (rsp_final_result)
   );

   // A report always takes a scan before the next one, so result strobes
   // never come in adjacent cycles.
   `LRTF_ASSERT_NEXT(a_rsp_spaced, rsp_valid, !rsp_valid)
   // A job never waits longer than its own turnaround.
   `LRTF_ASSERT_SAME(a_wait_le_tat, rsp_valid, rsp_waiting <= rsp_turnaround)
   // The report of the last job of a set coincides with the return to idle.
   `LRTF_ASSERT_SAME(a_final_idle, rsp_valid && rsp_final_result, !busy)
   // A run never starts without the marked transaction.
   `LRTF_ASSERT_NEXT(a_run_entry, !busy && !(start && req_last_job), !busy)

endmodule
